// ===== hdl/spc_pkg.sv =====
// Shared types and constants for the skin pixel classifier.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int PIX_W      = 8;    // one color component
    localparam int MILLI_W    = 18;   // Cb/Cr scaled by 1000
    localparam int HUE_W      = 12;   // hue bound, tenths of a degree
    localparam int DIFF_W     = PIX_W + 1;
    localparam int NUM_W      = 20;   // hue numerator and bound*d products
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // Color conversion coefficients, scaled by 1000
    localparam int CB_R       = 148;
    localparam int CB_G       = 291;
    localparam int CB_B       = 439;
    localparam int CR_R       = 439;
    localparam int CR_G       = 368;
    localparam int CR_B       = 71;
    localparam int C_OFFSET   = 128000;
    localparam int MILLI      = 1000;

    // Hue numerator terms, tenths of a degree
    localparam int HUE_STEP   = 600;
    localparam int HUE_GREEN  = 1200;
    localparam int HUE_BLUE   = 2400;
    localparam int HUE_WRAP   = 3600;

    // Reset values of the windows
    localparam logic [PIX_W-1:0] CR_LOW_RST  = 8'd140;
    localparam logic [PIX_W-1:0] CR_HIGH_RST = 8'd165;
    localparam logic [PIX_W-1:0] CB_LOW_RST  = 8'd140;
    localparam logic [PIX_W-1:0] CB_HIGH_RST = 8'd195;
    localparam logic [HUE_W-1:0] HUE_LOW_RST  = 12'd36;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST = 12'd360;

    typedef enum logic [2:0] {
        REG_CR_LOW   = 3'd0,
        REG_CR_HIGH  = 3'd1,
        REG_CB_LOW   = 3'd2,
        REG_CB_HIGH  = 3'd3,
        REG_HUE_LOW  = 3'd4,
        REG_HUE_HIGH = 3'd5
    } t_reg_idx;

    // Which component is the max (ties go red, then green)
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

endpackage

// ===== hdl/skin_pixel_classifier.sv =====
// Skin pixel classifier: RGB to Cb/Cr plus hue window test, three-stage pipeline.
`timescale 1ns / 1ps

// One RGB pixel in, one result out. Takes one pixel per clock when not
// stalled by back-pressure, through three register stages (stage 1: Cb, Cr,
// max/min and sector; stage 2: hue numerator and bound*d products, Cb/Cr
// window checks; stage 3: hue window check, output register). A result
// passes the stage 1, 2 and 3 registers in order before it reaches the
// output. Each stage holds only while the stage after it is full and
// stalled, so back-pressure never drops or repeats a pixel. Cb/Cr come out
// exact, times 1000 (tdata). The skin flag
// (tuser) is set when Cr, Cb and the HSV hue all lie in their inclusive
// windows. Hue is compared by cross-multiplying the bounds with max-min; a
// grey pixel counts as hue 0. Window registers sit on the APB port at byte
// addresses 0x00 cr_low, 0x04 cr_high, 0x08 cb_low, 0x0C cb_high,
// 0x10 hue_low_tenths, 0x14 hue_high_tenths; change them only while idle.
module skin_pixel_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [spc_pkg::S_TDATA_W-1:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    // stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spc_pkg::M_TDATA_W-1:0] m_axis_tdata,   // cb_milli[17:0], cr_milli[35:18], zero
    output logic                          m_axis_tuser,   // is_skin[0]
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spc_pkg::ADDR_W-1:0]    paddr,
    input  logic [spc_pkg::DATA_W-1:0]    pwdata,
    output logic [spc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import spc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [PIX_W-1:0] r_cr_low, r_cr_high, r_cb_low, r_cb_high;
    logic [HUE_W-1:0] r_hue_low, r_hue_high;
    t_reg_idx         w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_low   <= CR_LOW_RST;
            r_cr_high  <= CR_HIGH_RST;
            r_cb_low   <= CB_LOW_RST;
            r_cb_high  <= CB_HIGH_RST;
            r_hue_low  <= HUE_LOW_RST;
            r_hue_high <= HUE_HIGH_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CR_LOW:   r_cr_low   <= pwdata[PIX_W-1:0];
                REG_CR_HIGH:  r_cr_high  <= pwdata[PIX_W-1:0];
                REG_CB_LOW:   r_cb_low   <= pwdata[PIX_W-1:0];
                REG_CB_HIGH:  r_cb_high  <= pwdata[PIX_W-1:0];
                REG_HUE_LOW:  r_hue_low  <= pwdata[HUE_W-1:0];
                REG_HUE_HIGH: r_hue_high <= pwdata[HUE_W-1:0];
                default: ;   // unused addresses ignore writes
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CR_LOW:   prdata = DATA_W'(r_cr_low);
            REG_CR_HIGH:  prdata = DATA_W'(r_cr_high);
            REG_CB_LOW:   prdata = DATA_W'(r_cb_low);
            REG_CB_HIGH:  prdata = DATA_W'(r_cb_high);
            REG_HUE_LOW:  prdata = DATA_W'(r_hue_low);
            REG_HUE_HIGH: prdata = DATA_W'(r_hue_high);
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3        = !r_v3 || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 1: Cb, Cr, max/min, sector ----------------
    logic [PIX_W-1:0]   w_r, w_g, w_b;
    logic [MILLI_W-1:0] w_re, w_ge, w_be;
    logic [MILLI_W-1:0] n_cb1, n_cr1;
    logic [PIX_W-1:0]   w_mx, w_mn;
    t_sector            n_sec1;
    logic [DIFF_W-1:0]  n_diff1;

    assign w_r  = s_axis_tdata[PIX_W-1:0];
    assign w_g  = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign w_b  = s_axis_tdata[3*PIX_W-1:2*PIX_W];
    assign w_re = MILLI_W'(w_r);
    assign w_ge = MILLI_W'(w_g);
    assign w_be = MILLI_W'(w_b);

    // True results stay inside 18 bits, so wrap-around arithmetic is exact.
    assign n_cb1 = MILLI_W'(C_OFFSET) + MILLI_W'(CB_B) * w_be
                 - MILLI_W'(CB_R) * w_re - MILLI_W'(CB_G) * w_ge;
    assign n_cr1 = MILLI_W'(C_OFFSET) + MILLI_W'(CR_R) * w_re
                 - MILLI_W'(CR_G) * w_ge - MILLI_W'(CR_B) * w_be;

    always_comb begin
        if (w_r >= w_g && w_r >= w_b) begin
            n_sec1  = SEC_RED;
            w_mx    = w_r;
            n_diff1 = {1'b0, w_g} - {1'b0, w_b};
        end else if (w_g >= w_b) begin
            n_sec1  = SEC_GREEN;
            w_mx    = w_g;
            n_diff1 = {1'b0, w_b} - {1'b0, w_r};
        end else begin
            n_sec1  = SEC_BLUE;
            w_mx    = w_b;
            n_diff1 = {1'b0, w_r} - {1'b0, w_g};
        end
        w_mn = w_r;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
    end

    logic [MILLI_W-1:0] r_cb1, r_cr1;
    logic [PIX_W-1:0]   r_d1;
    logic [DIFF_W-1:0]  r_diff1;
    t_sector            r_sec1;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_cb1   <= n_cb1;
            r_cr1   <= n_cr1;
            r_d1    <= w_mx - w_mn;
            r_diff1 <= n_diff1;
            r_sec1  <= n_sec1;
        end
    end

    // ---------------- stage 2: hue numerator, bound products ----------------
    logic [NUM_W-1:0] w_d_ext, w_diff_ext, w_base, n_num2;
    logic             n_box2;

    assign w_d_ext    = NUM_W'(r_d1);
    assign w_diff_ext = {{(NUM_W-DIFF_W){r_diff1[DIFF_W-1]}}, r_diff1};

    always_comb begin
        case (r_sec1)
            SEC_RED:   w_base = r_diff1[DIFF_W-1] ? NUM_W'(HUE_WRAP) * w_d_ext : '0;
            SEC_GREEN: w_base = NUM_W'(HUE_GREEN) * w_d_ext;
            SEC_BLUE:  w_base = NUM_W'(HUE_BLUE) * w_d_ext;
            default:   w_base = '0;
        endcase
    end

    // numerator is never negative, wrap-around sum is exact
    assign n_num2 = w_base + NUM_W'(HUE_STEP) * w_diff_ext;

    assign n_box2 = (r_cr1 >= MILLI_W'(MILLI) * MILLI_W'(r_cr_low))
                 && (r_cr1 <= MILLI_W'(MILLI) * MILLI_W'(r_cr_high))
                 && (r_cb1 >= MILLI_W'(MILLI) * MILLI_W'(r_cb_low))
                 && (r_cb1 <= MILLI_W'(MILLI) * MILLI_W'(r_cb_high));

    logic [MILLI_W-1:0] r_cb2, r_cr2;
    logic [NUM_W-1:0]   r_num2, r_lod2, r_hid2;
    logic [PIX_W-1:0]   r_d2;
    logic               r_box2;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_cb2  <= r_cb1;
            r_cr2  <= r_cr1;
            r_num2 <= n_num2;
            r_lod2 <= NUM_W'(r_hue_low) * w_d_ext;
            r_hid2 <= NUM_W'(r_hue_high) * w_d_ext;
            r_d2   <= r_d1;
            r_box2 <= n_box2;
        end
    end

    // ---------------- stage 3: hue window, output register ----------------
    logic n_hue3;

    // grey pixel: hue is 0, window holds only with a zero low bound
    assign n_hue3 = (r_d2 == '0) ? (r_hue_low == '0)
                                 : (r_lod2 <= r_num2 && r_num2 <= r_hid2);

    logic [MILLI_W-1:0] r_cb3, r_cr3;
    logic               r_skin3;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_cb3   <= r_cb2;
            r_cr3   <= r_cr2;
            r_skin3 <= r_box2 && n_hue3;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tuser  = r_skin3;
    assign m_axis_tdata  = {{(M_TDATA_W-2*MILLI_W){1'b0}}, r_cr3, r_cb3};

    // ---------------- checks ----------------
    // skin result must satisfy the Cb/Cr windows
    a_skin_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_skin3) |->
            (r_cr3 >= MILLI_W'(MILLI) * MILLI_W'(r_cr_low)
             && r_cr3 <= MILLI_W'(MILLI) * MILLI_W'(r_cr_high)
             && r_cb3 >= MILLI_W'(MILLI) * MILLI_W'(r_cb_low)
             && r_cb3 <= MILLI_W'(MILLI) * MILLI_W'(r_cb_high)))
        else $error("skin flag set outside Cb/Cr window");

    // hue numerator stays at most a full turn
    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_num2 <= NUM_W'(HUE_WRAP) * NUM_W'(r_d2)))
        else $error("hue numerator out of range");

    // grey pixel with a nonzero low bound is never skin
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_rdy3 && r_d2 == '0 && r_hue_low != '0) |=> !r_skin3)
        else $error("grey pixel flagged as skin");

    // a stalled stage keeps its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_rdy2) |=> (r_v2 && $stable(r_num2) && $stable(r_cb2)))
        else $error("stalled stage lost its item");

    // nothing valid at the first edge out of reset
    a_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("valid set after reset");

endmodule
